// ===== rtl/wvcs_pkg.sv =====
// Shared types and constants for the wind vane circular smoother.
// Holds widths, status and opcode codes, the controller state type and
// the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package wvcs_pkg;

	// encoder counts in one full turn of the vane
	localparam int COUNTS_PER_TURN = 256;

	localparam int POS_W   = $clog2(COUNTS_PER_TURN);
	localparam int FRAC_W  = 16;
	localparam int SM_W    = POS_W + FRAC_W;
	localparam int DIFF_W  = POS_W + 1;
	localparam int PROD_W  = POS_W + 18;
	localparam int ALPHA_W = 16;

	localparam int ANGLE_SPAN = 360;
	localparam int ANG_W      = 9;
	localparam int P_W        = POS_W + ANG_W;
	localparam int SCALE_SH   = P_W;
	localparam int RC_W       = ANG_W + 1;

	// floor(2^SCALE_SH / COUNTS_PER_TURN); estimate is low by at most one
	localparam logic [RC_W-1:0] RECIP =
		RC_W'((longint'(1) << SCALE_SH) / COUNTS_PER_TURN);

	localparam logic signed [DIFF_W-1:0] HALF_D  = DIFF_W'(COUNTS_PER_TURN / 2);
	localparam logic signed [DIFF_W-1:0] NHALF_D = -HALF_D;
	localparam logic signed [DIFF_W-1:0] TURN_D  = DIFF_W'(COUNTS_PER_TURN);
	localparam logic signed [PROD_W-1:0] TURN_Q  =
		PROD_W'(longint'(COUNTS_PER_TURN) << FRAC_W);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(COUNTS_PER_TURN - 1);

	// configuration port
	localparam int CFG_AW = 1;
	localparam int CFG_W  = 16;
	localparam logic [CFG_AW-1:0] REG_ENABLE = 1'd0;
	localparam logic [CFG_AW-1:0] REG_ALPHA  = 1'd1;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd9830;

	// request kinds
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_NEW      = 2'd0;
	localparam logic [1:0] STAT_DISABLED = 2'd1;
	localparam logic [1:0] STAT_NOCHANGE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_UPD,
		S_SCALE,
		S_RECIP,
		S_FIX,
		S_STAT
	} state_t;

	typedef struct packed {
		logic       edge_step;
		logic       load_diff;
		logic       load_prod;
		logic       load_upd;
		logic       load_scale;
		logic       load_recip;
		logic       load_out;
		logic [1:0] out_status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic enable;
		logic changed;
	} dp_stat_t;

endpackage

// ===== rtl/wvcs_ctrl.sv =====
// Controller for the wind vane smoother: sequences one read through the
// datapath steps and owns the output valid. Depends on wvcs_pkg.
`timescale 1ns / 1ps

module wvcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_opcode,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  wvcs_pkg::dp_stat_t   stat,
	output wvcs_pkg::ctrl_cmd_t  cmd
);

	wvcs_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic [1:0]       stat_q;
	logic             accept;
	logic             out_free;
	logic             read_busy;

	assign accept    = in_valid && (state_q == wvcs_pkg::S_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign read_busy = stat.enable && stat.changed;

	always_comb begin
		state_d = state_q;
		case (state_q)
			wvcs_pkg::S_IDLE: begin
				if (accept && in_opcode == wvcs_pkg::OP_READ) begin
					state_d = read_busy ? wvcs_pkg::S_MUL : wvcs_pkg::S_STAT;
				end
			end
			wvcs_pkg::S_MUL:   state_d = wvcs_pkg::S_UPD;
			wvcs_pkg::S_UPD:   state_d = wvcs_pkg::S_SCALE;
			wvcs_pkg::S_SCALE: state_d = wvcs_pkg::S_RECIP;
			wvcs_pkg::S_RECIP: state_d = wvcs_pkg::S_FIX;
			wvcs_pkg::S_FIX, wvcs_pkg::S_STAT: begin
				if (out_free) begin
					state_d = wvcs_pkg::S_IDLE;
				end
			end
			default: state_d = wvcs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.out_status = stat_q;
		case (state_q)
			wvcs_pkg::S_IDLE: begin
				cmd.edge_step = accept && in_opcode == wvcs_pkg::OP_EDGE;
				cmd.load_diff = accept && in_opcode == wvcs_pkg::OP_READ;
			end
			wvcs_pkg::S_MUL:   cmd.load_prod  = 1'b1;
			wvcs_pkg::S_UPD:   cmd.load_upd   = 1'b1;
			wvcs_pkg::S_SCALE: cmd.load_scale = 1'b1;
			wvcs_pkg::S_RECIP: cmd.load_recip = 1'b1;
			wvcs_pkg::S_FIX: begin
				cmd.load_out   = out_free;
				cmd.out_status = wvcs_pkg::STAT_NEW;
			end
			wvcs_pkg::S_STAT: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wvcs_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			stat_q      <= wvcs_pkg::STAT_NEW;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load_diff) begin
				stat_q <= !stat.enable ? wvcs_pkg::STAT_DISABLED : wvcs_pkg::STAT_NOCHANGE;
			end
		end
	end

	assign in_ready  = (state_q == wvcs_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/wvcs_dpath.sv =====
// Datapath for the wind vane smoother: position counter, fixed point
// smoothed position, config registers, angle scaling and output register.
// Depends on wvcs_pkg.
`timescale 1ns / 1ps

module wvcs_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wvcs_pkg::ctrl_cmd_t           cmd,
	output wvcs_pkg::dp_stat_t            stat,
	input  logic                          b_level,
	input  logic                          cfg_we,
	input  logic [wvcs_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [wvcs_pkg::CFG_W-1:0]    cfg_wdata,
	output logic [1:0]                    out_status,
	output logic [wvcs_pkg::ANG_W-1:0]    out_angle
);

	localparam int POS_W  = wvcs_pkg::POS_W;
	localparam int SM_W   = wvcs_pkg::SM_W;
	localparam int DIFF_W = wvcs_pkg::DIFF_W;
	localparam int PROD_W = wvcs_pkg::PROD_W;
	localparam int P_W    = wvcs_pkg::P_W;
	localparam int ANG_W  = wvcs_pkg::ANG_W;
	localparam int RC_W   = wvcs_pkg::RC_W;

	logic                           enable_q;
	logic [wvcs_pkg::ALPHA_W-1:0]   alpha_q;
	logic [POS_W-1:0]               pos_q;
	logic [SM_W-1:0]                smooth_q;
	logic                           changed_q;

	logic signed [DIFF_W-1:0]       diff_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic [P_W-1:0]                 p_q;
	logic [ANG_W-1:0]               qe_q;
	logic [1:0]                     status_q;
	logic [ANG_W-1:0]               angle_q;

	logic [POS_W-1:0]               ip;
	logic [POS_W-1:0]               pos_next;
	logic signed [DIFF_W-1:0]       diff_raw, diff_wrap;
	logic signed [PROD_W-1:0]       prod_c;
	logic signed [PROD_W-1:0]       sum, sum_wrap;
	logic [P_W-1:0]                 scaled;
	logic [P_W+RC_W-1:0]            qprod;
	logic [P_W-1:0]                 back, rem;
	logic [ANG_W-1:0]               angle_fix;

	assign ip = smooth_q[SM_W-1:wvcs_pkg::FRAC_W];

	always_comb begin
		if (b_level) begin
			pos_next = (pos_q == wvcs_pkg::POS_LAST) ? '0 : pos_q + 1'b1;
		end else begin
			pos_next = (pos_q == '0) ? wvcs_pkg::POS_LAST : pos_q - 1'b1;
		end
	end

	// shortest way round; exactly half a turn stays as is
	always_comb begin
		diff_raw = $signed({1'b0, pos_q}) - $signed({1'b0, ip});
		if (diff_raw > wvcs_pkg::HALF_D) begin
			diff_wrap = diff_raw - wvcs_pkg::TURN_D;
		end else if (diff_raw < wvcs_pkg::NHALF_D) begin
			diff_wrap = diff_raw + wvcs_pkg::TURN_D;
		end else begin
			diff_wrap = diff_raw;
		end
	end

	assign prod_c = $signed({1'b0, alpha_q}) * diff_q;

	always_comb begin
		sum = $signed({2'b00, smooth_q}) + prod_q;
		if (sum >= wvcs_pkg::TURN_Q) begin
			sum_wrap = sum - wvcs_pkg::TURN_Q;
		end else if (sum[PROD_W-1]) begin
			sum_wrap = sum + wvcs_pkg::TURN_Q;
		end else begin
			sum_wrap = sum;
		end
	end

	// angle = ip * 360 / turn via reciprocal, then one correction step
	assign scaled    = {{ANG_W{1'b0}}, ip} * P_W'(wvcs_pkg::ANGLE_SPAN);
	assign qprod     = {{RC_W{1'b0}}, p_q} * {{P_W{1'b0}}, wvcs_pkg::RECIP};
	assign back      = {{POS_W{1'b0}}, qe_q} * P_W'(wvcs_pkg::COUNTS_PER_TURN);
	assign rem       = p_q - back;
	assign angle_fix = qe_q + ANG_W'(rem >= P_W'(wvcs_pkg::COUNTS_PER_TURN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			alpha_q   <= wvcs_pkg::ALPHA_RESET;
			pos_q     <= '0;
			smooth_q  <= '0;
			changed_q <= 1'b0;
		end else begin
			if (cmd.edge_step && enable_q) begin
				pos_q     <= pos_next;
				changed_q <= 1'b1;
			end
			if (cmd.load_upd) begin
				smooth_q  <= sum_wrap[SM_W-1:0];
				changed_q <= 1'b0;
			end
			if (cfg_we && cfg_addr == wvcs_pkg::REG_ENABLE) begin
				// start-up snaps the filter to the current count
				if (cfg_wdata[0] && !enable_q) begin
					smooth_q <= {pos_q, {wvcs_pkg::FRAC_W{1'b0}}};
				end
				enable_q <= cfg_wdata[0];
			end
			if (cfg_we && cfg_addr == wvcs_pkg::REG_ALPHA) begin
				alpha_q <= cfg_wdata[wvcs_pkg::ALPHA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_diff) begin
			diff_q <= diff_wrap;
		end
		if (cmd.load_prod) begin
			prod_q <= prod_c;
		end
		if (cmd.load_scale) begin
			p_q <= scaled;
		end
		if (cmd.load_recip) begin
			qe_q <= qprod[wvcs_pkg::SCALE_SH +: ANG_W];
		end
		if (cmd.load_out) begin
			status_q <= cmd.out_status;
			angle_q  <= (cmd.out_status == wvcs_pkg::STAT_NEW) ? angle_fix : '0;
		end
	end

	assign stat.enable  = enable_q;
	assign stat.changed = changed_q;
	assign out_status   = status_q;
	assign out_angle    = angle_q;

endmodule

// ===== rtl/wind_vane_circular_smoother.sv =====
// Top level of the wind vane circular smoother.
// Instantiates wvcs_ctrl and wvcs_dpath; depends on wvcs_pkg.
//
// Usage:
//  - Input stream s_axis_*: tuser is the request kind (0 = channel A rising
//    edge, 1 = read), tdata[0] is the channel B level for edges.
//  - Output stream m_axis_*: one result per read. tuser is the status
//    (0 new angle, 1 not enabled, 2 no change), tdata[8:0] the angle in
//    degrees, zero unless status is 0.
//  - cfg_we/cfg_addr/cfg_wdata: register 0 enable, register 1 alpha (Q0.16).
//    Write only while the block is idle.
//  - An edge request, if enabled, steps the position on acceptance. A read that
//    updates the filter runs diff, multiply, update, x360, reciprocal
//    multiply, correction; a status-only read skips them. One request is
//    in work at a time, set by the shared sequencer in the controller.
//  - Result waits in an output register; if the receiver stalls the last
//    step holds until the register drains, and s_axis_tready stays low.
//  - Reset: disabled, alpha 9830, position and filter zero, no change pending.
`timescale 1ns / 1ps

module wind_vane_circular_smoother (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [0] b_level, [7:1] zero
	input  logic                          s_axis_tuser,  // [0] opcode
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [15:0]                   m_axis_tdata,  // [8:0] angle, [15:9] zero
	output logic [1:0]                    m_axis_tuser,  // [1:0] status
	input  logic                          cfg_we,
	input  logic [wvcs_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [wvcs_pkg::CFG_W-1:0]    cfg_wdata
);

	wvcs_pkg::ctrl_cmd_t        cmd;
	wvcs_pkg::dp_stat_t         stat;
	logic [wvcs_pkg::ANG_W-1:0] angle;

	wvcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_opcode (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	wvcs_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.b_level    (s_axis_tdata[0]),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.out_status (m_axis_tuser),
		.out_angle  (angle)
	);

	assign m_axis_tdata = {{(16 - wvcs_pkg::ANG_W){1'b0}}, angle};

endmodule

// ===== rtl/wvcs_checker.sv =====
// Port-level checks for wind_vane_circular_smoother, attached by bind.
// Depends on wvcs_pkg and the top level's port list.
`timescale 1ns / 1ps

module wvcs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [15:0]                   m_axis_tdata,
	input logic [1:0]                    m_axis_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// status-only results carry a zero angle
	a_stat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != wvcs_pkg::STAT_NEW |->
			m_axis_tdata == 16'd0 &&
			(m_axis_tuser == wvcs_pkg::STAT_DISABLED ||
			 m_axis_tuser == wvcs_pkg::STAT_NOCHANGE))
		else $error("bad status result");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == wvcs_pkg::STAT_NEW |->
			m_axis_tdata < 16'(wvcs_pkg::ANGLE_SPAN))
		else $error("angle out of range");

	// a read keeps the sequencer busy in the following cycle
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == wvcs_pkg::OP_READ |=>
			!s_axis_tready)
		else $error("request taken during read");

endmodule

bind wind_vane_circular_smoother wvcs_checker u_wvcs_checker (.*);
